FILE: src/lsm_pkg.sv
// Shared types and constants for the processor load smoother.
`timescale 1ns / 1ps
package lsm_pkg;

  // Q1.16 load values and Q1.8 weights
  localparam int unsigned LOAD_W = 17;
  localparam logic [LOAD_W-1:0] ONE_Q16 = 17'h10000;
  localparam int unsigned WEIGHT_W = 9;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd179;

  // Ratio divider yields one quotient bit per step
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned TICK_W = 32;

  // Queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Sample class found by the front part
  typedef enum logic [1:0] {
    KIND_DIVIDE = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_FULL   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TICK_W-1:0] busy_ticks;
    logic [TICK_W-1:0] total_ticks;
  } in_item_t;

  typedef struct packed {
    logic [LOAD_W-1:0] raw_load;
    logic [LOAD_W-1:0] window_average;
    logic [LOAD_W-1:0] smoothed_load;
    logic              zero_interval;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] busy;
    logic [TICK_W-1:0] total;
    kind_e             kind;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: src/cpu_load_smoother.sv
// Top level of the processor load smoother: front, queue, back and weight register.
// A result passes through the ratio divider when a division is needed and skips it otherwise.
// The back part handles one transaction at a time; its ratio divider produces
// one quotient bit per cycle.
// Two transactions may wait in the queue while the back part is busy.
// Reset clears the history, counters and average and sets the weight to 179.
`timescale 1ns / 1ps
module cpu_load_smoother #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lsm_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lsm_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lsm_pkg::WEIGHT_W-1:0] cfg_wdata_i
);
  import lsm_pkg::*;

  push_t               push;
  job_t                job;
  queue_status_t       queue_status;
  logic                pop;
  logic [WEIGHT_W-1:0] weight_q;

  // Hold the exponential weight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  lsm_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .queue_status_i (queue_status),
    .push_o         (push)
  );

  lsm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .job_o    (job),
    .status_o (queue_status)
  );

  lsm_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .weight_i       (weight_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

  // Loads stay within one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.raw_load <= ONE_Q16) &&
                    (out_data_o.window_average <= ONE_Q16) &&
                    (out_data_o.smoothed_load <= ONE_Q16))
    else $error("load above one");

  // An empty interval reports zero load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_interval |-> out_data_o.raw_load == '0)
    else $error("zero interval with nonzero load");

  // The back part never takes from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !queue_status.empty)
    else $error("pop from empty queue");

  // A queue that was full and not drained stays full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_status.full && !pop |=> queue_status.full)
    else $error("queue lost an entry");

endmodule

FILE: src/lsm_front.sv
// Front part: takes sample transactions and classifies them for the back part.
`timescale 1ns / 1ps
module lsm_front (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lsm_pkg::in_item_t      in_data_i,
  input  lsm_pkg::queue_status_t queue_status_i,
  output lsm_pkg::push_t         push_o
);
  import lsm_pkg::*;

  kind_e kind;

  // Classify: empty interval, busy at or above total, or a true division
  always_comb begin
    if (in_data_i.total_ticks == '0) begin
      kind = KIND_ZERO;
    end else if (in_data_i.busy_ticks >= in_data_i.total_ticks) begin
      kind = KIND_FULL;
    end else begin
      kind = KIND_DIVIDE;
    end
  end

  // Hold off the sender while the queue is full
  assign in_stall_o = queue_status_i.full;

  assign push_o.valid     = in_valid_i && !queue_status_i.full;
  assign push_o.job.busy  = in_data_i.busy_ticks;
  assign push_o.job.total = in_data_i.total_ticks;
  assign push_o.job.kind  = kind;

endmodule

FILE: src/lsm_queue.sv
// Short job queue that decouples the front and back parts.
`timescale 1ns / 1ps
module lsm_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsm_pkg::push_t         push_i,
  input  logic                   pop_i,
  output lsm_pkg::job_t          job_o,
  output lsm_pkg::queue_status_t status_o
);
  import lsm_pkg::*;

  job_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign do_push = push_i.valid && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  assign job_o           = mem_q[rd_ptr_q];
  assign status_o.full   = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status_o.empty  = (count_q == '0);

endmodule

FILE: src/lsm_back.sv
// Back part: serial ratio divider, window mean and exponential average.
`timescale 1ns / 1ps
module lsm_back #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsm_pkg::job_t                job_i,
  input  lsm_pkg::queue_status_t       queue_status_i,
  output logic                         pop_o,
  input  logic [lsm_pkg::WEIGHT_W-1:0] weight_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lsm_pkg::out_item_t           out_data_o
);
  import lsm_pkg::*;

  localparam int unsigned PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SEEN_W  = $clog2(WINDOW + 2);
  localparam int unsigned SUM_W   = LOAD_W + $clog2(WINDOW + 1);
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned EMA_W   = LOAD_W + WEIGHT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_AVG  = 3'd3;
  localparam logic [2:0] ST_EMA  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [TICK_W-1:0] divisor_q, divisor_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [LOAD_W-1:0] raw_q, raw_d;
  logic              zero_q, zero_d;
  logic              first_q, first_d;
  logic [LOAD_W-1:0] avg_q, avg_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [LOAD_W-1:0] last_q, last_d;
  logic [LOAD_W-1:0] hist_q [WINDOW];
  logic              hist_we;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic [TICK_W:0]     rem_shift;
  logic                rem_ge;
  logic [PROD_W-1:0]   avg_prod;
  logic [WEIGHT_W-1:0] weight_sat;
  logic [EMA_W-1:0]    ema_sum;
  logic [LOAD_W-1:0]   smooth;
  logic                out_free;

  // One restoring division step
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, divisor_q});

  // Window mean by reciprocal multiply, exact for every reachable sum
  assign avg_prod = PROD_W'(sum_q) * PROD_W'(RECIP_W'(RECIP));

  // Exponential average with weight clamped at one
  assign weight_sat = (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;
  assign ema_sum = EMA_W'(weight_sat) * EMA_W'(raw_q)
                 + EMA_W'(WEIGHT_ONE - weight_sat) * EMA_W'(last_q);
  assign smooth = first_q ? raw_q : ema_sum[WEIGHT_W-1 +: LOAD_W];

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    divisor_d   = divisor_q;
    quot_d      = quot_q;
    step_d      = step_q;
    raw_d       = raw_q;
    zero_d      = zero_q;
    first_d     = first_q;
    avg_d       = avg_q;
    sum_d       = sum_q;
    ptr_d       = ptr_q;
    seen_d      = seen_q;
    last_d      = last_q;
    hist_we     = 1'b0;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (!queue_status_i.empty) begin
          pop_o     = 1'b1;
          rem_d     = job_i.busy;
          divisor_d = job_i.total;
          step_d    = STEP_W'(QUOT_W - 1);
          zero_d    = (job_i.kind == KIND_ZERO);
          case (job_i.kind)
            KIND_ZERO: begin
              raw_d   = '0;
              state_d = ST_SUM;
            end
            KIND_FULL: begin
              raw_d   = ONE_Q16;
              state_d = ST_SUM;
            end
            default: begin
              state_d = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d  = rem_ge ? TICK_W'(rem_shift - {1'b0, divisor_q}) : rem_shift[TICK_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], rem_ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          raw_d   = {1'b0, quot_d};
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        // Replace the oldest load and keep the running sum in step
        hist_we = 1'b1;
        sum_d   = sum_q - SUM_W'(hist_q[ptr_q]) + SUM_W'(raw_q);
        ptr_d   = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
        first_d = (seen_q == '0);
        if (seen_q < SEEN_W'(WINDOW + 1)) begin
          seen_d = seen_q + 1'b1;
        end
        state_d = ST_AVG;
      end
      ST_AVG: begin
        avg_d   = (seen_q <= SEEN_W'(WINDOW)) ? raw_q : avg_prod[SHIFT +: LOAD_W];
        state_d = ST_EMA;
      end
      ST_EMA: begin
        if (out_free) begin
          last_d                    = smooth;
          out_valid_d               = 1'b1;
          out_data_d.raw_load       = raw_q;
          out_data_d.window_average = avg_q;
          out_data_d.smoothed_load  = smooth;
          out_data_d.zero_interval  = zero_q;
          state_d                   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      ptr_q       <= '0;
      seen_q      <= '0;
      last_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      ptr_q       <= ptr_d;
      seen_q      <= seen_d;
      last_q      <= last_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load history starts cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_q[i] <= '0;
      end
    end else if (hist_we) begin
      hist_q[ptr_q] <= raw_q;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    divisor_q  <= divisor_d;
    quot_q     <= quot_d;
    step_q     <= step_d;
    raw_q      <= raw_d;
    zero_q     <= zero_d;
    avg_q      <= avg_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
